FILE: sv/trep_pkg.sv
// ----------------------------------------------------------------------------
// trep_pkg
// Shared widths and the job record passed from the row front end to the
// residual back end.
// ----------------------------------------------------------------------------
package trep_pkg;

    localparam int DW     = 32;           // data width of each Q.16 value (16..32)
    localparam int FW     = 32;           // field width on the stream bus
    localparam int FRAC   = 16;           // fraction bits
    localparam int SW     = 2 * DW + 3;   // exact residual sum width
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Residual A: row finished by the arrival of its successor.
    // Residual B: the last row itself.
    typedef struct packed {
        logic                 a_valid;
        logic                 b_valid;
        logic                 last;
        logic signed [DW-1:0] a_po;
        logic signed [DW-1:0] a_px;
        logic signed [DW:0]   a_dmu;
        logic signed [DW-1:0] a_cx;
        logic signed [DW-1:0] a_co;
        logic signed [DW-1:0] a_nx;
        logic signed [DW-1:0] b_po;
        logic signed [DW-1:0] b_px;
        logic signed [DW:0]   b_dmu;
        logic signed [DW-1:0] b_x;
    } job_t;

endpackage

FILE: sv/trep_front.sv
// ----------------------------------------------------------------------------
// trep_front
// Accepts matrix rows, keeps the three-row window and the eigenvalue, and
// issues residual jobs.
// ----------------------------------------------------------------------------
module trep_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,    // diag_value, offd_value, x_value
    input  logic                  s_tlast,    // last_row
    output trep_pkg::job_t        job,
    output logic                  job_valid,
    input  logic                  job_ready
);
    import trep_pkg::*;

    logic signed [DW-1:0] eig_reg;
    logic signed [DW-1:0] prev_x_reg;
    logic signed [DW-1:0] cur_x_reg;
    logic signed [DW-1:0] cur_diag_reg;
    logic signed [DW-1:0] prev_offd_reg;
    logic signed [DW-1:0] cur_offd_reg;
    logic                 pending_reg;

    logic signed [DW-1:0] d_in;
    logic signed [DW-1:0] o_in;
    logic signed [DW-1:0] x_in;
    logic                 accept;

    assign d_in      = s_tdata[DW-1:0];
    assign o_in      = s_tdata[FW+DW-1:FW];
    assign x_in      = s_tdata[2*FW+DW-1:2*FW];
    assign cfg_ready = 1'b1;
    assign s_tready  = job_ready;
    assign accept    = s_tvalid & job_ready;
    assign job_valid = accept & (pending_reg | s_tlast);

    always_comb
    begin
        job.a_valid = pending_reg;
        job.b_valid = s_tlast;
        job.last    = s_tlast;
        job.a_po    = prev_offd_reg;
        job.a_px    = prev_x_reg;
        job.a_dmu   = (DW+1)'(cur_diag_reg) - (DW+1)'(eig_reg);
        job.a_cx    = cur_x_reg;
        job.a_co    = cur_offd_reg;
        job.a_nx    = x_in;
        job.b_po    = pending_reg ? cur_offd_reg : '0;
        job.b_px    = pending_reg ? cur_x_reg : '0;
        job.b_dmu   = (DW+1)'(d_in) - (DW+1)'(eig_reg);
        job.b_x     = x_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eig_reg <= '0;
        end
        else if (cfg_valid)
        begin
            eig_reg <= cfg_data[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            cur_x_reg     <= '0;
            cur_diag_reg  <= '0;
            prev_offd_reg <= '0;
            cur_offd_reg  <= '0;
            pending_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                prev_x_reg    <= '0;
                cur_x_reg     <= '0;
                cur_diag_reg  <= '0;
                prev_offd_reg <= '0;
                cur_offd_reg  <= '0;
                pending_reg   <= 1'b0;
            end
            else
            begin
                prev_x_reg    <= pending_reg ? cur_x_reg : '0;
                prev_offd_reg <= pending_reg ? cur_offd_reg : '0;
                cur_x_reg     <= x_in;
                cur_diag_reg  <= d_in;
                cur_offd_reg  <= o_in;
                pending_reg   <= 1'b1;
            end
        end
    end

endmodule

FILE: sv/trep_queue.sv
// ----------------------------------------------------------------------------
// trep_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module trep_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  trep_pkg::job_t push_job,
    input  logic           push_valid,
    output logic           push_ready,
    output trep_pkg::job_t pop_job,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import trep_pkg::*;

    job_t           store_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/trep_back.sv
// ----------------------------------------------------------------------------
// trep_back
// Residual pipeline: products, exact sums, magnitude and saturation, running
// maximum and the result register.
// ----------------------------------------------------------------------------
module trep_back (
    input  logic           clk,
    input  logic           rst_n,
    input  trep_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,    // residual_norm
    output logic           m_tuser     // saturated
);
    import trep_pkg::*;

    function automatic logic [DW:0] quantize(input logic signed [SW-1:0] s);
        logic [SW-1:0]      mag;
        logic [SW-FRAC-1:0] qf;
        logic [DW:0]        r;
        mag = s[SW-1] ? unsigned'(-s) : unsigned'(s);
        qf  = mag[SW-1:FRAC];
        if (|qf[SW-FRAC-1:DW])
        begin
            r = {1'b1, {DW{1'b1}}};
        end
        else
        begin
            r = {1'b0, qf[DW-1:0]};
        end
        return r;
    endfunction

    logic en;

    // stage 1: products
    logic                   s1_v_reg, s1_a_reg, s1_b_reg, s1_last_reg;
    logic signed [2*DW-1:0] pa0_reg, pa2_reg, pb0_reg;
    logic signed [2*DW:0]   pa1_reg, pb1_reg;
    logic signed [2*DW-1:0] pa0_next, pa2_next, pb0_next;
    logic signed [2*DW:0]   pa1_next, pb1_next;

    // stage 2: sums
    logic                 s2_v_reg, s2_a_reg, s2_b_reg, s2_last_reg;
    logic signed [SW-1:0] sa_reg, sb_reg;
    logic signed [SW-1:0] sa_next, sb_next;

    // stage 3: quantized magnitudes
    logic          s3_v_reg, s3_last_reg;
    logic [DW-1:0] qa_reg, qb_reg;
    logic          sata_reg, satb_reg;
    logic [DW:0]   qa_next, qb_next;

    // stage 4: running max and output
    logic [DW-1:0] run_reg, max_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;
    logic          out_sat_reg;

    assign en        = !out_valid_reg | m_tready;
    assign job_ready = en;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = FW'(out_data_reg);
    assign m_tuser   = out_sat_reg;

    always_comb
    begin
        pa0_next = job.a_po * job.a_px;
        pa1_next = job.a_dmu * job.a_cx;
        pa2_next = job.a_co * job.a_nx;
        pb0_next = job.b_po * job.b_px;
        pb1_next = job.b_dmu * job.b_x;
        sa_next  = SW'(pa0_reg) + SW'(pa1_reg) + SW'(pa2_reg);
        sb_next  = SW'(pb0_reg) + SW'(pb1_reg);
        qa_next  = s2_a_reg ? quantize(sa_reg) : '0;
        qb_next  = s2_b_reg ? quantize(sb_reg) : '0;
        max_next = run_reg;
        if (qa_reg > max_next)
        begin
            max_next = qa_reg;
        end
        if (qb_reg > max_next)
        begin
            max_next = qb_reg;
        end
        ovf_next = ovf_reg | sata_reg | satb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa0_reg <= pa0_next;
            pa1_reg <= pa1_next;
            pa2_reg <= pa2_next;
            pb0_reg <= pb0_next;
            pb1_reg <= pb1_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            qa_reg  <= qa_next[DW-1:0];
            qb_reg  <= qb_next[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s1_a_reg      <= 1'b0;
            s1_b_reg      <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_v_reg      <= 1'b0;
            s2_a_reg      <= 1'b0;
            s2_b_reg      <= 1'b0;
            s2_last_reg   <= 1'b0;
            s3_v_reg      <= 1'b0;
            s3_last_reg   <= 1'b0;
            sata_reg      <= 1'b0;
            satb_reg      <= 1'b0;
            run_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_sat_reg   <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= job_valid;
            s1_a_reg    <= job_valid & job.a_valid;
            s1_b_reg    <= job_valid & job.b_valid;
            s1_last_reg <= job_valid & job.last;
            s2_v_reg    <= s1_v_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_last_reg <= s1_last_reg;
            s3_v_reg    <= s2_v_reg;
            s3_last_reg <= s2_last_reg;
            sata_reg    <= qa_next[DW];
            satb_reg    <= qb_next[DW];
            out_valid_reg <= s3_v_reg & s3_last_reg;
            if (s3_v_reg)
            begin
                if (s3_last_reg)
                begin
                    out_data_reg <= max_next;
                    out_sat_reg  <= ovf_next;
                    run_reg      <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    run_reg <= max_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

endmodule

FILE: sv/tridiagonal_eigenpair_residual_top.sv
// ----------------------------------------------------------------------------
// tridiagonal_eigenpair_residual_top
// L-infinity residual norm of a candidate eigenpair of a symmetric
// tridiagonal matrix, one matrix row per input beat.
// ----------------------------------------------------------------------------
// One row (diagonal, off-diagonal to the next row, vector element) is taken
// per cycle, sustained, for any mix of rows and vectors; the front end only
// stalls when the four-entry job queue is full, which happens only while the
// result beat is held by m_tready low. The residual of a row is formed when
// its successor arrives; on the row with tlast the norm of the whole vector
// appears on the result port once that beat has passed the job queue and the
// product, sum, magnitude and max-fold pipeline stages of the back end. The
// eigenvalue register is written through cfg and must only change between
// vectors, once the previous result has been taken.
module tridiagonal_eigenpair_residual_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,    // eigenvalue
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,     // diag_value, offd_value, x_value
    input  logic        s_tlast,     // last_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // residual_norm
    output logic        m_tuser      // saturated
);
    import trep_pkg::*;

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_ready;

    trep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    trep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    trep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: sv/trep_checker.sv
// ----------------------------------------------------------------------------
// trep_checker
// Port-level checks on the residual norm block, bound to the top level.
// ----------------------------------------------------------------------------
module trep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [31:0] cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    import trep_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[DW-1:0] == {DW{1'b1}})
        else $error("saturated result below full scale");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("eigenvalue write not taken");

endmodule

bind tridiagonal_eigenpair_residual_top trep_checker u_trep_checker (.*);

FILE: sim/trep_norm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trep_norm_checker
// Watches the config, row and norm channels, predicts the residual norm of
// each vector from the rows accepted, and compares it with each norm beat.
// ----------------------------------------------------------------------------
module trep_norm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          results_waiting,
    output int          rows_seen,
    output int          vectors_done,
    output int          sat_norms
);
    import trep_pkg::*;

    typedef struct packed {
        logic [31:0] norm;
        logic        sat;
    } norm_beat_t;

    norm_beat_t norm_expected[$];
    norm_beat_t want;

    logic signed [DW-1:0] eig_q;
    logic signed [DW-1:0] prev_x, cur_x, cur_diag, prev_offd, cur_offd;
    logic signed [DW-1:0] row_d, row_o, row_x;
    logic [DW-1:0]        running_max;
    logic                 row_pending;
    logic                 overflow_seen;

    // |po*px + dg*xc + on*xn - u*xc|, truncated to Q.16, saturated to full scale, folded into the max
    task automatic fold_into_max(input logic signed [DW-1:0] po, px, dg, xc, on, xn);
        logic signed [95:0] w_po, w_px, w_d, w_x, w_o, w_n, w_u, sum;
        logic [95:0]        mag;
        w_po = po;
        w_px = px;
        w_d  = dg;
        w_x  = xc;
        w_o  = on;
        w_n  = xn;
        w_u  = eig_q;
        sum  = w_po * w_px + w_d * w_x + w_o * w_n - w_u * w_x;
        mag  = (sum < 0) ? -sum : sum;
        mag  = mag >> FRAC;
        if (mag > {{(96-DW){1'b0}}, {DW{1'b1}}})
        begin
            mag           = {{(96-DW){1'b0}}, {DW{1'b1}}};
            overflow_seen = 1'b1;
        end
        if (mag[DW-1:0] > running_max)
            running_max = mag[DW-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_expected.delete();
            eig_q         = '0;
            prev_x        = '0;
            cur_x         = '0;
            cur_diag      = '0;
            prev_offd     = '0;
            cur_offd      = '0;
            running_max   = '0;
            row_pending   = 1'b0;
            overflow_seen = 1'b0;
            fail_count    = 0;
            rows_seen     = 0;
            vectors_done  = 0;
            sat_norms     = 0;
            results_waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                eig_q = cfg_data[DW-1:0];

            if (m_tvalid && m_tready)
            begin
                if (norm_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected norm beat: expected none, got %h sat %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = norm_expected.pop_front();
                    if (m_tdata !== want.norm)
                    begin
                        fail_count++;
                        $display("%0t residual_norm mismatch: expected %h, got %h",
                                 $time, want.norm, m_tdata);
                    end
                    if (m_tuser !== want.sat)
                    begin
                        fail_count++;
                        $display("%0t saturated mismatch: expected %b, got %b",
                                 $time, want.sat, m_tuser);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                row_d = s_tdata[0*FW +: DW];
                row_o = s_tdata[1*FW +: DW];
                row_x = s_tdata[2*FW +: DW];
                rows_seen++;
                // previous row is finished by this one
                if (row_pending)
                begin
                    fold_into_max(prev_offd, prev_x, cur_diag, cur_x, cur_offd, row_x);
                    prev_x    = cur_x;
                    prev_offd = cur_offd;
                end
                else
                begin
                    prev_x    = '0;
                    prev_offd = '0;
                end
                cur_x    = row_x;
                cur_diag = row_d;
                cur_offd = s_tlast ? '0 : row_o;

                if (!s_tlast)
                    row_pending = 1'b1;
                else
                begin
                    fold_into_max(prev_offd, prev_x, cur_diag, cur_x, '0, '0);
                    want.norm = running_max;
                    want.sat  = overflow_seen;
                    norm_expected.push_back(want);
                    vectors_done++;
                    if (overflow_seen)
                        sat_norms++;
                    prev_x        = '0;
                    cur_x         = '0;
                    cur_diag      = '0;
                    prev_offd     = '0;
                    cur_offd      = '0;
                    running_max   = '0;
                    row_pending   = 1'b0;
                    overflow_seen = 1'b0;
                end
            end

            results_waiting <= norm_expected.size();
        end
    end

endmodule

FILE: sim/tb_tridiagonal_eigenpair_residual_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tridiagonal_eigenpair_residual_top
// Drives matrix rows and eigenvalue writes into the residual-norm block under
// several idle/stall mixes; the checker predicts and compares every norm.
// ----------------------------------------------------------------------------
module tb_tridiagonal_eigenpair_residual_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ROWS    = 105;
    localparam int DRAIN_WAIT  = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;      // eigenvalue
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;       // diag_value, offd_value, x_value
    logic        s_tlast;       // last_row
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // residual_norm
    logic        m_tuser;       // saturated

    int          fail_count;
    int          results_waiting;
    int          rows_seen;
    int          vectors_done;
    int          sat_norms;

    int          src_idle  = 0;
    int          rcv_stall = 0;
    int          hold_len  = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;
    logic [31:0] cur_eig = '0;

    tridiagonal_eigenpair_residual_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    trep_norm_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .rows_seen       (rows_seen),
        .vectors_done    (vectors_done),
        .sat_norms       (sat_norms)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            m_tready <= 1'b0;
            hold_len <= hold_len - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_tridiagonal_eigenpair_residual_top failed");
            $finish;
        end
    end

    // mix of near-zero, full-range and corner values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: v = {{11{v[20]}}, v[20:0]};
            4, 5, 6:    v = v;
            7:          v = {{15{v[16]}}, v[16:0]};
            default:
            begin
                case ($urandom_range(6))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0001_0000;
                    5: v = 32'hFFFF_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_row(input logic [31:0] d, o, x, input logic last);
        s_tdata  <= {x, o, d};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending until every norm is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_waiting != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_eigenvalue(input logic [31:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_eig = v;
        cfg_writes++;
    endtask

    task automatic send_vector(input int len, output int sent);
        logic exact;
        logic [31:0] d, o, x;
        // exact: d = u and no coupling, so every residual is zero
        exact = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++)
        begin
            d = exact ? cur_eig : pick_value();
            o = exact ? 32'h0 : pick_value();
            x = pick_value();
            send_row(d, o, x, i == len - 1);
        end
        sent = len;
    endtask

    initial
    begin
        int seg_rows;
        int n;
        logic [31:0] eig;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: eigenvalue still at its reset value of zero
        send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_row(32'h4000_4000, 32'h0000_0000, 32'h0003_FFFC, 1'b1);  // norm = full scale
        send_row(32'h4000_4000, 32'h0000_0000, 32'h0003_FFFD, 1'b1);  // just past it
        send_row(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0);
        send_row(32'h0002_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1);  // last offd ignored
        drain();
        set_eigenvalue(32'h0001_0000);
        send_row(32'h0003_0000, 32'h0000_0000, 32'h0002_0000, 1'b1);
        send_row(32'h0001_0000, 32'h0000_0000, 32'h1234_5678, 1'b0);
        send_row(32'h0001_0000, 32'h0000_0000, 32'hFEDC_BA98, 1'b0);
        send_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
        send_row(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);  // tiny, truncates
        send_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1);
        drain();
        set_eigenvalue(32'h8000_0000);
        send_row(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        send_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
        drain();
        set_eigenvalue(32'h7FFF_FFFF);
        send_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin src_idle = 0;  rcv_stall = 0;  end
                1: begin src_idle = 59; rcv_stall = 0;  end
                2: begin src_idle = 0;  rcv_stall = 59; end
                default: begin src_idle = 35; rcv_stall = 35; end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                drain();
                case (p * 4 + s)
                    0: eig = 32'h8000_0000;
                    1: eig = 32'h7FFF_FFFF;
                    2: eig = 32'h0000_0000;
                    3: eig = 32'h0001_0000;
                    default: eig = pick_value();
                endcase
                set_eigenvalue(eig);
                seg_rows = 0;
                while (seg_rows < SEG_ROWS)
                begin
                    if ($urandom_range(9) == 0)
                        send_vector($urandom_range(9, 40), n);
                    else
                        send_vector($urandom_range(1, 8), n);
                    seg_rows += n;
                end
            end
            if (p == 0)
            begin
                // long receiver hold-off while short vectors keep coming
                hold_len <= 300;
                for (int k = 0; k < 24; k++)
                    send_vector($urandom_range(1, 2), n);
                drain();
            end
        end

        drain();
        repeat (12) @(posedge clk);

        $display("covered %0d rows in %0d vectors over %0d eigenvalue writes",
                 rows_seen, vectors_done, cfg_writes);
        $display("%0d norms saturated; idle mixes none, sender, receiver, both",
                 sat_norms);
        if (fail_count == 0 && results_waiting == 0)
            $display("tb_tridiagonal_eigenpair_residual_top passed");
        else
            $display("tb_tridiagonal_eigenpair_residual_top failed");
        $finish;
    end

endmodule
